// ===== hdl/sha1s_pkg.sv =====
// package with shared types and constants for the sha-1 stream hasher
package sha1s_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic [1:0]  status;
    logic        last_word;
  } out_word_t;

  localparam logic [1:0] ST_DIGEST   = 2'd0;
  localparam logic [1:0] ST_SEALED   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // command codes passed from front to back
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_ERR  = 2'd1,
    CMD_END  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic [1:0] err;
    logic       do_end;
  } cmd_word_t;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam int QDEPTH = 2;

  function automatic logic [31:0] round_k(input logic [6:0] i);
    if (i < 7'd20) return 32'h5A827999;
    else if (i < 7'd40) return 32'h6ED9EBA1;
    else if (i < 7'd60) return 32'h8F1BBCDC;
    else return 32'hCA62C1D6;
  endfunction

endpackage

// ===== hdl/sha1s_front.sv =====
// front end: classifies input words and tracks sealed state and bit count
module sha1s_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1s_pkg::in_word_t  in_data,
  output logic                 cmd_valid,
  input  logic                 cmd_stall,
  output sha1s_pkg::cmd_word_t cmd_data
);
  import sha1s_pkg::*;

  logic [63:0] bit_count_r, bit_count_nxt;
  logic        sealed_r, sealed_nxt;
  logic        too_long;

  assign too_long = (bit_count_r >= 64'hFFFF_FFFF_FFFF_FFF7);
  assign in_stall = cmd_stall;
  assign cmd_valid = in_valid && (in_data.has_byte || in_data.end_of_message);

  // classify
  always_comb begin
    cmd_data = '0;
    cmd_data.data_byte = in_data.data_byte;
    cmd_data.cmd = CMD_END;
    cmd_data.do_end = in_data.end_of_message;
    bit_count_nxt = bit_count_r;
    sealed_nxt = sealed_r;
    if (in_data.has_byte && sealed_r) begin
      cmd_data.cmd = CMD_ERR;
      cmd_data.err = ST_SEALED;
    end else if (in_data.has_byte && too_long) begin
      cmd_data.cmd = CMD_ERR;
      cmd_data.err = ST_TOO_LONG;
    end else begin
      if (in_data.has_byte) begin
        cmd_data.cmd = CMD_BYTE;
        bit_count_nxt = bit_count_r + 64'd8;
      end
      if (in_data.end_of_message) begin
        bit_count_nxt = '0;
        sealed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= '0;
      sealed_r <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      bit_count_r <= bit_count_nxt;
      sealed_r <= sealed_nxt;
    end
  end
endmodule

// ===== hdl/sha1s_queue.sv =====
// short command queue between front and back
module sha1s_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_stall,
  input  sha1s_pkg::cmd_word_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_stall,
  output sha1s_pkg::cmd_word_t rd_data
);
  import sha1s_pkg::*;

  cmd_word_t mem_r [QDEPTH];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      wr_en, rd_en;

  assign wr_stall = (cnt_r == 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && !wr_stall;
  assign rd_en = rd_valid && !rd_stall;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

// ===== hdl/sha1s_back.sv =====
// back end: block buffer, 80-round compression, padding and digest output
module sha1s_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  sha1s_pkg::cmd_word_t  cmd_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1s_pkg::out_word_t  out_data
);
  import sha1s_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_LEN  = 6'b000100,
    S_RND  = 6'b001000,
    S_ADD  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t      state_r;
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_r;
  logic        final_r;   // compression belongs to the padding pass
  logic        sealed_r;
  logic        pad_one_r; // 0x80 already placed
  logic        cmd_data_end_r;
  logic [2:0]  idx_r;
  logic        ov_r;
  out_word_t   od_r;
  logic [31:0] f, t, wnew, wcur;
  logic        take, ofree, ld_out;

  assign ofree = !ov_r || !out_stall;
  assign cmd_stall = !(state_r == S_IDLE && ofree);
  assign take = cmd_valid && !cmd_stall;
  assign out_valid = ov_r;
  assign out_data = od_r;
  assign ld_out = (take && cmd_data.cmd == CMD_ERR) || (state_r == S_EMIT && ofree);

  // round function
  assign wcur = w_r[0];
  assign wnew = {w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]} << 1 |
                {w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]} >> 31;
  always_comb begin
    if (rnd_r < 7'd20) f = (b_r & c_r) | (~b_r & d_r);
    else if (rnd_r < 7'd40 || rnd_r >= 7'd60) f = b_r ^ c_r ^ d_r;
    else f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    t = {a_r[26:0], a_r[31:27]} + f + e_r + wcur + round_k(rnd_r);
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ld_out) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
      fill_r <= '0;
      len_r <= '0;
      sealed_r <= 1'b0;
      final_r <= 1'b0;
      pad_one_r <= 1'b0;
      rnd_r <= '0;
      idx_r <= '0;
      for (int i = 0; i < 16; i++) w_r[i] <= '0;
    end else begin
      case (state_r)
        // accept a command
        S_IDLE: begin
          if (take) begin
            case (cmd_data.cmd)
              CMD_ERR: begin
                od_r <= '{digest_word: '0, word_index: '0, status: cmd_data.err,
                          last_word: 1'b1};
              end
              CMD_BYTE: begin
                w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= cmd_data.data_byte;
                fill_r <= fill_r + 6'd1;
                len_r <= len_r + 64'd8;
                final_r <= 1'b0;
                pad_one_r <= 1'b0;
                if (fill_r == 6'd63) state_r <= S_RND;
                else if (cmd_data.do_end) state_r <= sealed_r ? S_EMIT : S_PAD;
              end
              default: begin
                pad_one_r <= 1'b0;
                state_r <= sealed_r ? S_EMIT : S_PAD;
              end
            endcase
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
            e_r <= h_r[4];
            rnd_r <= '0;
            idx_r <= '0;
          end
        end
        // append 0x80 and zero the tail
        S_PAD: begin
          if (!pad_one_r) begin
            w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= 8'h80;
            pad_one_r <= 1'b1;
            fill_r <= fill_r + 6'd1;
            if (fill_r == 6'd55) state_r <= S_LEN;
            else if (fill_r == 6'd63) begin
              final_r <= 1'b0;
              state_r <= S_RND;
            end
          end else begin
            w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= 8'h00;
            fill_r <= fill_r + 6'd1;
            if (fill_r == 6'd55) state_r <= S_LEN;
            else if (fill_r == 6'd63) begin
              final_r <= 1'b0;
              state_r <= S_RND;
            end
          end
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          e_r <= h_r[4];
          rnd_r <= '0;
        end
        // length words
        S_LEN: begin
          w_r[14] <= len_r[63:32];
          w_r[15] <= len_r[31:0];
          final_r <= 1'b1;
          state_r <= S_RND;
        end
        // one round a cycle; word buffer shifts as schedule window
        S_RND: begin
          e_r <= d_r;
          d_r <= c_r;
          c_r <= {b_r[1:0], b_r[31:2]};
          b_r <= a_r;
          a_r <= t;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) state_r <= S_ADD;
        end
        // fold into chaining value
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          fill_r <= '0;
          for (int i = 0; i < 16; i++) w_r[i] <= '0;
          a_r <= h_r[0] + a_r; b_r <= h_r[1] + b_r; c_r <= h_r[2] + c_r;
          d_r <= h_r[3] + d_r; e_r <= h_r[4] + e_r;
          rnd_r <= '0;
          if (final_r) begin
            len_r <= '0;
            sealed_r <= 1'b1;
            state_r <= S_EMIT;
          end else if (pad_one_r) state_r <= S_PAD;
          else if (cmd_data_end_r) state_r <= S_PAD;
          else state_r <= S_IDLE;
        end
        // emit five digest words
        S_EMIT: begin
          if (ofree) begin
            od_r <= '{digest_word: h_r[idx_r], word_index: idx_r,
                      status: ST_DIGEST, last_word: (idx_r == 3'd4)};
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd4) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // remember a pending end when a byte fills the block
  always_ff @(posedge clk) begin
    if (!rst_n) cmd_data_end_r <= 1'b0;
    else if (take) cmd_data_end_r <= (cmd_data.cmd == CMD_BYTE) && cmd_data.do_end;
  end
endmodule

// ===== hdl/sha1_stream_hasher.sv =====
// top level of the sha-1 stream hasher
// Accepts one word per item carrying an optional message byte and an end
// flag, and returns five big-endian digest words per end, or one error word.
// Each 64th byte and each end of an unsealed message start the 80-round
// compression, one round a cycle followed by a fold into the chaining value,
// and padding writes one byte a cycle. A two-entry command queue lets the
// front end keep accepting while the back end works.
module sha1_stream_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1s_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1s_pkg::out_word_t out_data
);
  import sha1s_pkg::*;

  logic      f_valid, f_stall, b_valid, b_stall;
  cmd_word_t f_data, b_data;

  sha1s_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd_data(f_data)
  );

  sha1s_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
  );

  sha1s_back u_back (
    .clk, .rst_n,
    .cmd_valid(b_valid), .cmd_stall(b_stall), .cmd_data(b_data),
    .out_valid, .out_stall, .out_data
  );
endmodule
